// File: design/csv_field_splitter_assert.svh
// Assertion macros for the csv_field_splitter RTL.
// Each expects a clock named clk and an active-low reset named rst_n in scope.
`ifndef CSV_FIELD_SPLITTER_ASSERT_SVH
`define CSV_FIELD_SPLITTER_ASSERT_SVH

// Condition must hold at every clock edge out of reset.
`define CSVFS_ASSERT_ALWAYS(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("csv_field_splitter: assertion failed");

// Antecedent in one cycle implies consequent in the next.
`define CSVFS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("csv_field_splitter: assertion failed");

`endif

// File: design/csvfs_pkg.sv
// ----------------------------------------------------------------------------
// csvfs_pkg
// Shared types and character codes for the CSV field splitter.
// ----------------------------------------------------------------------------
`default_nettype none

package csvfs_pkg;

  typedef enum logic [1:0] {
    MODE_START = 2'd0,
    MODE_UNQ   = 2'd1,
    MODE_QUO   = 2'd2,
    MODE_QPEND = 2'd3
  } csvfs_mode_t;

  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_NUL   = 8'h00;

  localparam logic [7:0]  COL_MAX     = 8'hFF;
  localparam logic [11:0] LIMIT_RESET = 12'd299;

  // Fixed-width part of one result; kept_length travels beside it.
  typedef struct packed {
    logic       is_field_end;
    logic [7:0] data_byte;
    logic [7:0] field_number;
    logic       line_end;
    logic       last;
  } csvfs_res_t;

endpackage

`default_nettype wire

// File: design/csvfs_parser.sv
// ----------------------------------------------------------------------------
// csvfs_parser
// Input byte register, parse mode machine and field counters. Produces up to
// two results per byte when the result queue has room for two.
// ----------------------------------------------------------------------------
`default_nettype none

module csvfs_parser #(
  parameter int LENGTH_WIDTH = 12
) (
  input  wire                      clk,
  input  wire                      rst_n,
  input  wire                      in_valid,
  output logic                     in_stall,
  input  wire  [7:0]               in_text_byte,
  input  wire  [11:0]              field_limit,
  input  wire                      room,
  output logic [1:0]               push_cnt,
  output csvfs_pkg::csvfs_res_t    push_a_res,
  output logic [LENGTH_WIDTH-1:0]  push_a_len,
  output csvfs_pkg::csvfs_res_t    push_b_res,
  output logic [LENGTH_WIDTH-1:0]  push_b_len
);

  localparam int CW = (LENGTH_WIDTH > 12) ? LENGTH_WIDTH : 12;
  localparam logic [LENGTH_WIDTH-1:0] LEN_MAX = {LENGTH_WIDTH{1'b1}};

  logic                     stage_valid_r, stage_valid_nxt;
  logic [7:0]               byte_r;
  csvfs_pkg::csvfs_mode_t   mode_r, mode_nxt;
  logic [LENGTH_WIDTH-1:0]  cnt_r, cnt_nxt;
  logic [7:0]               col_r, col_nxt;

  logic                     accept, fire, term;
  logic                     do_end, end_le, want_keep, keep_ok;
  logic [7:0]               keep_val, col_after_end;
  logic [LENGTH_WIDTH-1:0]  base_cnt;
  logic [7:0]               base_col;
  csvfs_pkg::csvfs_mode_t   mode_parse;

  assign fire     = stage_valid_r && room;
  assign in_stall = stage_valid_r && !room;
  assign accept   = in_valid && !in_stall;

  always_comb begin
    stage_valid_nxt = stage_valid_r;
    if (accept) begin
      stage_valid_nxt = 1'b1;
    end else if (fire) begin
      stage_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stage_valid_r <= 1'b0;
      mode_r        <= csvfs_pkg::MODE_START;
      cnt_r         <= '0;
      col_r         <= '0;
    end else begin
      stage_valid_r <= stage_valid_nxt;
      mode_r        <= mode_nxt;
      cnt_r         <= cnt_nxt;
      col_r         <= col_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      byte_r <= in_text_byte;
    end
  end

  assign term = (byte_r == csvfs_pkg::CH_NUL) || (byte_r == csvfs_pkg::CH_CR) ||
                (byte_r == csvfs_pkg::CH_LF);

  // Classify the byte against the current mode.
  always_comb begin
    do_end     = 1'b0;
    end_le     = 1'b0;
    want_keep  = 1'b0;
    keep_val   = byte_r;
    mode_parse = mode_r;
    unique case (mode_r)
      csvfs_pkg::MODE_START: begin
        if (byte_r == csvfs_pkg::CH_QUOTE) begin
          mode_parse = csvfs_pkg::MODE_QUO;
        end else if (byte_r == csvfs_pkg::CH_COMMA) begin
          do_end = 1'b1;
        end else if (term) begin
          do_end = 1'b1;
          end_le = 1'b1;
        end else begin
          mode_parse = csvfs_pkg::MODE_UNQ;
          want_keep  = 1'b1;
        end
      end
      csvfs_pkg::MODE_UNQ: begin
        if (byte_r == csvfs_pkg::CH_COMMA) begin
          do_end = 1'b1;
        end else if (term) begin
          do_end = 1'b1;
          end_le = 1'b1;
        end else begin
          want_keep = 1'b1;
        end
      end
      csvfs_pkg::MODE_QUO: begin
        if (byte_r == csvfs_pkg::CH_QUOTE) begin
          mode_parse = csvfs_pkg::MODE_QPEND;
        end else if (byte_r == csvfs_pkg::CH_NUL) begin
          do_end = 1'b1;
          end_le = 1'b1;
        end else begin
          want_keep = 1'b1;
        end
      end
      csvfs_pkg::MODE_QPEND: begin
        if (byte_r == csvfs_pkg::CH_QUOTE) begin
          mode_parse = csvfs_pkg::MODE_QUO;
          want_keep  = 1'b1;
          keep_val   = csvfs_pkg::CH_QUOTE;
        end else if (byte_r == csvfs_pkg::CH_COMMA) begin
          do_end = 1'b1;
        end else if (term) begin
          do_end = 1'b1;
          end_le = 1'b1;
        end else begin
          // closing quote followed by text: close field, text opens the next
          do_end     = 1'b1;
          mode_parse = csvfs_pkg::MODE_UNQ;
          want_keep  = 1'b1;
        end
      end
      default: begin
        mode_parse = csvfs_pkg::MODE_START;
      end
    endcase
    if (do_end && !want_keep) begin
      mode_parse = csvfs_pkg::MODE_START;
    end
  end

  always_comb begin
    if (end_le) begin
      col_after_end = '0;
    end else if (col_r == csvfs_pkg::COL_MAX) begin
      col_after_end = col_r;
    end else begin
      col_after_end = col_r + 8'd1;
    end
    base_cnt = do_end ? '0 : cnt_r;
    base_col = do_end ? col_after_end : col_r;
    keep_ok  = want_keep && (CW'(base_cnt) < CW'(field_limit)) && (base_cnt != LEN_MAX);
  end

  always_comb begin
    mode_nxt = mode_r;
    cnt_nxt  = cnt_r;
    col_nxt  = col_r;
    if (fire) begin
      mode_nxt = mode_parse;
      col_nxt  = base_col;
      cnt_nxt  = keep_ok ? base_cnt + 1'b1 : base_cnt;
    end
  end

  // Slot A carries the field end when there is one, else the data byte.
  always_comb begin
    push_cnt = '0;
    if (fire) begin
      push_cnt = {1'b0, do_end} + {1'b0, keep_ok};
    end

    push_b_res.is_field_end = 1'b0;
    push_b_res.data_byte    = keep_val;
    push_b_res.field_number = base_col;
    push_b_res.line_end     = 1'b0;
    push_b_res.last         = 1'b1;
    push_b_len              = base_cnt + 1'b1;

    if (do_end) begin
      push_a_res.is_field_end = 1'b1;
      push_a_res.data_byte    = '0;
      push_a_res.field_number = col_r;
      push_a_res.line_end     = end_le;
      push_a_res.last         = !keep_ok;
      push_a_len              = cnt_r;
    end else begin
      push_a_res = push_b_res;
      push_a_len = push_b_len;
    end
  end

endmodule

`default_nettype wire

// File: design/csvfs_out_fifo.sv
// ----------------------------------------------------------------------------
// csvfs_out_fifo
// Four-entry result queue. Takes up to two results per cycle, presents one.
// ----------------------------------------------------------------------------
`default_nettype none

`include "csv_field_splitter_assert.svh"

module csvfs_out_fifo #(
  parameter int LENGTH_WIDTH = 12
) (
  input  wire                        clk,
  input  wire                        rst_n,
  input  wire  [1:0]                 push_cnt,
  input  wire csvfs_pkg::csvfs_res_t push_a_res,
  input  wire  [LENGTH_WIDTH-1:0]    push_a_len,
  input  wire csvfs_pkg::csvfs_res_t push_b_res,
  input  wire  [LENGTH_WIDTH-1:0]    push_b_len,
  output logic                       room,
  output logic                       out_valid,
  input  wire                        out_stall,
  output csvfs_pkg::csvfs_res_t      out_res,
  output logic [LENGTH_WIDTH-1:0]    out_len
);

  localparam int DEPTH = 4;
  localparam int AW    = 2;

  csvfs_pkg::csvfs_res_t    res_mem [DEPTH];
  logic [LENGTH_WIDTH-1:0]  len_mem [DEPTH];

  logic [AW-1:0] wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [AW:0]   count_r, count_nxt;
  logic          pop;
  logic [AW-1:0] wr_ptr_b;

  assign room      = (count_r <= (AW+1)'(DEPTH - 2));
  assign out_valid = (count_r != '0);
  assign pop       = out_valid && !out_stall;
  assign wr_ptr_b  = wr_ptr_r + 1'b1;
  assign out_res   = res_mem[rd_ptr_r];
  assign out_len   = len_mem[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r + push_cnt;
    rd_ptr_nxt = pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r + {1'b0, push_cnt} - {{AW{1'b0}}, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push_cnt != 2'd0) begin
      res_mem[wr_ptr_r] <= push_a_res;
      len_mem[wr_ptr_r] <= push_a_len;
    end
    if (push_cnt == 2'd2) begin
      res_mem[wr_ptr_b] <= push_b_res;
      len_mem[wr_ptr_b] <= push_b_len;
    end
  end

  `CSVFS_ASSERT_ALWAYS(a_count_bound, count_r <= (AW+1)'(DEPTH))
  `CSVFS_ASSERT_ALWAYS(a_push_needs_room, (push_cnt == 2'd0) || room)
  `CSVFS_ASSERT_ALWAYS(a_push_cnt_range, push_cnt != 2'd3)
  `CSVFS_ASSERT_NEXT(a_hold_on_stall, out_valid && out_stall && (push_cnt == 2'd0), $stable(count_r) && $stable(rd_ptr_r))

endmodule

`default_nettype wire

// File: design/csv_field_splitter.sv
// ----------------------------------------------------------------------------
// csv_field_splitter
// Splits a byte stream into comma-separated fields with quoted-field support.
// ----------------------------------------------------------------------------
// Path: an accepted byte is registered in the parser, then its results are
//   written to the result queue. Throughput: one byte per cycle unless
//   in_stall signals too little queue room; results leave one at a time.
// Reset: synchronous active-low; parser returns to field start, counters to
//   zero, field_limit to 299, result queue empties.
`default_nettype none

module csv_field_splitter #(
  parameter int LENGTH_WIDTH = 12
) (
  input  wire                     clk,
  input  wire                     rst_n,
  input  wire                     cfg_wr_en,
  input  wire  [11:0]             cfg_wr_data,
  input  wire                     in_valid,
  output logic                    in_stall,
  input  wire  [7:0]              in_text_byte,
  output logic                    out_valid,
  input  wire                     out_stall,
  output logic                    out_is_field_end,
  output logic [7:0]              out_data_byte,
  output logic [7:0]              out_field_number,
  output logic [LENGTH_WIDTH-1:0] out_kept_length,
  output logic                    out_line_end,
  output logic                    out_last
);

  logic [11:0]              field_limit_r;
  logic                     room;
  logic [1:0]               push_cnt;
  csvfs_pkg::csvfs_res_t    push_a_res, push_b_res, out_res;
  logic [LENGTH_WIDTH-1:0]  push_a_len, push_b_len;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      field_limit_r <= csvfs_pkg::LIMIT_RESET;
    end else if (cfg_wr_en) begin
      field_limit_r <= cfg_wr_data;
    end
  end

  csvfs_parser #(
    .LENGTH_WIDTH(LENGTH_WIDTH)
  ) u_parser (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_text_byte (in_text_byte),
    .field_limit  (field_limit_r),
    .room         (room),
    .push_cnt     (push_cnt),
    .push_a_res   (push_a_res),
    .push_a_len   (push_a_len),
    .push_b_res   (push_b_res),
    .push_b_len   (push_b_len)
  );

  csvfs_out_fifo #(
    .LENGTH_WIDTH(LENGTH_WIDTH)
  ) u_out_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_cnt   (push_cnt),
    .push_a_res (push_a_res),
    .push_a_len (push_a_len),
    .push_b_res (push_b_res),
    .push_b_len (push_b_len),
    .room       (room),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_res    (out_res),
    .out_len    (out_kept_length)
  );

  assign out_is_field_end = out_res.is_field_end;
  assign out_data_byte    = out_res.data_byte;
  assign out_field_number = out_res.field_number;
  assign out_line_end     = out_res.line_end;
  assign out_last         = out_res.last;

endmodule

`default_nettype wire
